FILE: rtl/pidt_pkg.sv
// ----------------------------------------------------------------------------
// pidt_pkg
// shared widths, codes and constants of the trapezoidal pid step
// ----------------------------------------------------------------------------
package pidt_pkg;

    // field widths
    localparam int DATA_W    = 32;
    localparam int LIMIT_W   = 31;
    localparam int IN_W      = 16;
    localparam int DT_W      = 16;
    localparam int ERR_W     = IN_W + 1;
    localparam int ACC_W     = 48;
    localparam int FRAC_BITS = 16;

    // shared multiplier and divider
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 32;
    localparam int PROD_W    = 64;
    localparam int DIV_STEPS = 4;
    localparam int DIV_ITERS = PROD_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    // scaling constants
    localparam int INTEG_DIV   = 2000;
    localparam int DERIV_SCALE = 1000;

    localparam logic signed [PROD_W-1:0] ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [PROD_W-1:0] ACC_MIN = 64'shFFFF_8000_0000_0000;
    localparam logic signed [PROD_W-1:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] OUT_MIN = 64'shFFFF_FFFF_8000_0000;

    // operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // register map
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_INTEG_LIMIT = 3'd3,
        CFG_DRIVE_LIMIT = 3'd4,
        CFG_FEED_FWD    = 3'd5
    } t_cfg_idx;

endpackage

FILE: rtl/pidt_in_if.sv
// ----------------------------------------------------------------------------
// pidt_in_if
// command channel: step or clear, setpoint, measurement and step time
// ----------------------------------------------------------------------------
interface pidt_in_if;
    import pidt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   op;
    logic signed [IN_W-1:0] setpoint;
    logic signed [IN_W-1:0] measured;
    logic [DT_W-1:0]        step_ms;

    modport source (output valid, output op, output setpoint, output measured,
                    output step_ms, input ready);
    modport sink   (input valid, input op, input setpoint, input measured,
                    input step_ms, output ready);
endinterface

FILE: rtl/pidt_out_if.sv
// ----------------------------------------------------------------------------
// pidt_out_if
// result channel: controller drive
// ----------------------------------------------------------------------------
interface pidt_out_if;
    import pidt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

FILE: rtl/pidt_mul.sv
// ----------------------------------------------------------------------------
// pidt_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module pidt_mul (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [pidt_pkg::MUL_A_W-1:0]   i_a,
    input  logic [pidt_pkg::MUL_B_W-1:0]   i_b,
    output logic [pidt_pkg::PROD_W-1:0]    o_prod
);
    import pidt_pkg::*;

    logic [MUL_A_W+MUL_B_W-1:0] full_prod;
    logic [PROD_W-1:0]          r_prod;

    // operands are bounded so the product never exceeds 64 bits
    assign full_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= full_prod[PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;
endmodule

FILE: rtl/pidt_div.sv
// ----------------------------------------------------------------------------
// pidt_div
// iterative unsigned divider, 64-bit dividend by 16-bit divisor, 4 bits a cycle
// ----------------------------------------------------------------------------
module pidt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pidt_pkg::PROD_W-1:0]   i_dividend,
    input  logic [pidt_pkg::DT_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [pidt_pkg::PROD_W-1:0]   o_quotient
);
    import pidt_pkg::*;

    logic [PROD_W-1:0]    r_quo;
    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [PROD_W-1:0]    n_quo;
    logic [DT_W-1:0]      n_rem;
    logic [DT_W:0]        trial;
    logic [DT_W:0]        trial_sub;

    // restoring steps: dividend bits shift out the top, quotient bits in the bottom
    always_comb begin
        n_quo     = r_quo;
        n_rem     = r_rem;
        trial     = '0;
        trial_sub = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial     = {n_rem, n_quo[PROD_W-1]};
            trial_sub = trial - {1'b0, r_dvs};
            n_quo     = {n_quo[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                n_rem    = trial_sub[DT_W-1:0];
                n_quo[0] = 1'b1;
            end else begin
                n_rem    = trial[DT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= DIV_CNT_W'(DIV_ITERS - 1);
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

FILE: rtl/pid_controller_trapezoidal_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_trapezoidal_unit
// pid step with trapezoidal integral in signed q16.16, clamps and integer drive
//
// Each step transaction forms e = setpoint - measured, adds
// integ_gain*step_ms*(e+prev_error)/2000 to the integral (clamped to
// +-integral_limit, or to the 48-bit range when the limit is 0), forms
// prop_gain*e + integral + feed_forward_term plus
// deriv_gain*(e-prev_error)*1000/step_ms when step_ms is nonzero, clamps that to
// +-drive_limit whole units when drive_limit is nonzero, and returns it truncated
// toward zero and saturated to 32 bits. A clear transaction zeroes the integral
// and the last error and returns nothing. One multiplier and one 4-bit-per-cycle
// divider are shared under a small sequencer, and the command side is ready
// only while the sequencer is idle. A step makes two divider passes, the second
// only when step_ms is nonzero. The result sits in an output register, so the
// next command is taken while a result still waits. The user must see that the
// registers are written only while the block is idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module pid_controller_trapezoidal_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pidt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pidt_pkg::DATA_W-1:0]       i_cfg_data,
    pidt_in_if.sink                           i_cmd,
    pidt_out_if.source                        o_res
);
    import pidt_pkg::*;

    // sequencer, one-hot, one state for each use of the shared units and each datapath step
    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_MSD   = 13'b0000000000010,   // |e+prev| * dt
        ST_MKI   = 13'b0000000000100,   // |ki| * that
        ST_DIVI  = 13'b0000000001000,   // start /2000, |kp| * |e|
        ST_KP    = 13'b0000000010000,   // drive = kp*e + ff, |e-prev| * 1000
        ST_MDIFF = 13'b0000000100000,   // |kd| * that
        ST_WAITI = 13'b0000001000000,   // wait integral quotient
        ST_ISAT  = 13'b0000010000000,   // clamp integral, start /dt
        ST_IACC  = 13'b0000100000000,   // drive += integral
        ST_WAITD = 13'b0001000000000,   // wait derivative quotient
        ST_CLAMP = 13'b0010000000000,   // drive limit
        ST_OUT   = 13'b0100000000000,   // truncate, saturate, hand over
        ST_SPARE = 13'b1000000000000
    } t_state;

    // configuration
    logic signed [DATA_W-1:0] r_prop_gain;
    logic signed [DATA_W-1:0] r_integ_gain;
    logic signed [DATA_W-1:0] r_deriv_gain;
    logic [LIMIT_W-1:0]       r_integ_limit;
    logic [LIMIT_W-1:0]       r_drive_limit;
    logic signed [DATA_W-1:0] r_feed_fwd;

    // controller state
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [ACC_W-1:0]  r_int;

    // per-step working registers
    t_state                   r_state;
    t_state                   n_state;
    logic signed [ERR_W-1:0]  r_err;
    logic [DT_W-1:0]          r_dt;
    logic signed [PROD_W-1:0] r_drv;
    logic signed [PROD_W-1:0] r_tmp;
    logic                     r_sign_i;
    logic                     r_sign_p;
    logic                     r_sign_d;

    // output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_drive;

    // shared unit hookup
    logic                     mul_en;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [PROD_W-1:0]        mul_prod;
    logic                     div_start;
    logic [DT_W-1:0]          div_divisor;
    logic                     div_done;
    logic [PROD_W-1:0]        div_quo;

    // operand preparation
    logic signed [ERR_W:0]    sum_w;
    logic signed [ERR_W:0]    diff_w;
    logic [ERR_W:0]           sum_neg;
    logic [ERR_W:0]           diff_neg;
    logic [ERR_W-1:0]         err_neg;
    logic [ERR_W-1:0]         sum_mag;
    logic [ERR_W-1:0]         diff_mag;
    logic [ERR_W-1:0]         err_mag;
    logic [DATA_W-1:0]        kp_mag;
    logic [DATA_W-1:0]        ki_mag;
    logic [DATA_W-1:0]        kd_mag;
    logic signed [PROD_W-1:0] prod_s;
    logic signed [PROD_W-1:0] quo_s;
    logic signed [PROD_W-1:0] kp_term;
    logic signed [PROD_W-1:0] inc_term;
    logic signed [PROD_W-1:0] der_term;
    logic signed [PROD_W-1:0] ff_ext;
    logic signed [PROD_W-1:0] int_ext;
    logic signed [PROD_W-1:0] ilim_s;
    logic signed [PROD_W-1:0] dcap_s;
    logic signed [PROD_W-1:0] n_int_w;
    logic signed [PROD_W-1:0] n_drv_clamped;
    logic signed [PROD_W-1:0] drv_biased;
    logic signed [PROD_W-1:0] whole_w;
    logic signed [DATA_W-1:0] n_whole;
    logic                     cmd_acc;
    logic                     out_load;

    assign cmd_acc  = i_cmd.valid && i_cmd.ready;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_res.ready);

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.drive = r_out_drive;

    // magnitudes and signs, products run unsigned
    assign sum_w    = {r_err[ERR_W-1], r_err} + {r_prev[ERR_W-1], r_prev};
    assign diff_w   = {r_err[ERR_W-1], r_err} - {r_prev[ERR_W-1], r_prev};
    assign sum_neg  = -sum_w;
    assign diff_neg = -diff_w;
    assign err_neg  = -r_err;
    assign sum_mag  = sum_w[ERR_W]  ? sum_neg[ERR_W-1:0]  : sum_w[ERR_W-1:0];
    assign diff_mag = diff_w[ERR_W] ? diff_neg[ERR_W-1:0] : diff_w[ERR_W-1:0];
    assign err_mag  = r_err[ERR_W-1] ? err_neg : r_err;
    assign kp_mag   = r_prop_gain[DATA_W-1]  ? -r_prop_gain  : r_prop_gain;
    assign ki_mag   = r_integ_gain[DATA_W-1] ? -r_integ_gain : r_integ_gain;
    assign kd_mag   = r_deriv_gain[DATA_W-1] ? -r_deriv_gain : r_deriv_gain;

    assign prod_s   = signed'(mul_prod);
    assign quo_s    = signed'(div_quo);
    assign kp_term  = r_sign_p ? -prod_s : prod_s;
    assign inc_term = r_sign_i ? -quo_s : quo_s;
    assign der_term = r_sign_d ? -quo_s : quo_s;
    assign ff_ext   = signed'({{(PROD_W-DATA_W){r_feed_fwd[DATA_W-1]}}, r_feed_fwd});
    assign int_ext  = signed'({{(PROD_W-ACC_W){r_int[ACC_W-1]}}, r_int});
    assign ilim_s   = signed'({{(PROD_W-LIMIT_W){1'b0}}, r_integ_limit});
    assign dcap_s   = signed'({{(PROD_W-LIMIT_W-FRAC_BITS){1'b0}}, r_drive_limit,
                               {FRAC_BITS{1'b0}}});

    // integral limit; a nonzero limit lies inside the 48-bit range, so it
    // replaces the range saturation instead of following it
    always_comb begin
        n_int_w = r_tmp;
        if (r_integ_limit != '0) begin
            if (r_tmp > ilim_s) begin
                n_int_w = ilim_s;
            end else if (r_tmp < -ilim_s) begin
                n_int_w = -ilim_s;
            end
        end else begin
            if (r_tmp > ACC_MAX) begin
                n_int_w = ACC_MAX;
            end else if (r_tmp < ACC_MIN) begin
                n_int_w = ACC_MIN;
            end
        end
    end

    // drive limit in whole units
    always_comb begin
        n_drv_clamped = r_drv;
        if (r_drive_limit != '0) begin
            if (r_drv > dcap_s) begin
                n_drv_clamped = dcap_s;
            end else if (r_drv < -dcap_s) begin
                n_drv_clamped = -dcap_s;
            end
        end
    end

    // truncate toward zero: bias negatives before the arithmetic shift
    assign drv_biased = r_drv[PROD_W-1] ? r_drv + 64'sd65535 : r_drv;
    assign whole_w    = drv_biased >>> FRAC_BITS;

    always_comb begin
        if (whole_w > OUT_MAX) begin
            n_whole = OUT_MAX[DATA_W-1:0];
        end else if (whole_w < OUT_MIN) begin
            n_whole = OUT_MIN[DATA_W-1:0];
        end else begin
            n_whole = whole_w[DATA_W-1:0];
        end
    end

    // shared unit operand selection
    always_comb begin
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_divisor = r_dt;
        unique case (r_state)
            ST_MSD: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(sum_mag);
                mul_b  = MUL_B_W'(r_dt);
            end
            ST_MKI: begin
                mul_en = 1'b1;
                mul_a  = mul_prod[MUL_A_W-1:0];
                mul_b  = ki_mag;
            end
            ST_DIVI: begin
                mul_en      = 1'b1;
                mul_a       = MUL_A_W'(err_mag);
                mul_b       = kp_mag;
                div_start   = 1'b1;
                div_divisor = DT_W'(INTEG_DIV);
            end
            ST_KP: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(diff_mag);
                mul_b  = MUL_B_W'(DERIV_SCALE);
            end
            ST_MDIFF: begin
                mul_en = 1'b1;
                mul_a  = mul_prod[MUL_A_W-1:0];
                mul_b  = kd_mag;
            end
            ST_ISAT: begin
                // derivative only for a nonzero step time
                div_start = (r_dt != '0);
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_acc && i_cmd.op == OP_STEP) begin
                    n_state = ST_MSD;
                end
            end
            ST_MSD:   n_state = ST_MKI;
            ST_MKI:   n_state = ST_DIVI;
            ST_DIVI:  n_state = ST_KP;
            ST_KP:    n_state = ST_MDIFF;
            ST_MDIFF: n_state = ST_WAITI;
            ST_WAITI: begin
                if (div_done) begin
                    n_state = ST_ISAT;
                end
            end
            ST_ISAT:  n_state = ST_IACC;
            ST_IACC:  n_state = ST_WAITD;
            ST_WAITD: begin
                if (r_dt == '0 || div_done) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state, configuration and controller memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_integ_limit <= '0;
            r_drive_limit <= '0;
            r_feed_fwd    <= '0;
            r_prev        <= '0;
            r_int         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PROP_GAIN:   r_prop_gain   <= signed'(i_cfg_data);
                    CFG_INTEG_GAIN:  r_integ_gain  <= signed'(i_cfg_data);
                    CFG_DERIV_GAIN:  r_deriv_gain  <= signed'(i_cfg_data);
                    CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_FEED_FWD:    r_feed_fwd    <= signed'(i_cfg_data);
                    default: begin
                    end
                endcase
            end

            if (cmd_acc && i_cmd.op == OP_CLEAR) begin
                r_prev <= '0;
                r_int  <= '0;
            end else if (r_state == ST_ISAT) begin
                r_int <= n_int_w[ACC_W-1:0];
            end else if (out_load) begin
                r_prev <= r_err;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-step datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_err <= ERR_W'(i_cmd.setpoint) - ERR_W'(i_cmd.measured);
                r_dt  <= i_cmd.step_ms;
            end
            ST_MSD: begin
                r_sign_i <= r_integ_gain[DATA_W-1] ^ sum_w[ERR_W];
            end
            ST_DIVI: begin
                r_sign_p <= r_prop_gain[DATA_W-1] ^ r_err[ERR_W-1];
            end
            ST_KP: begin
                r_drv    <= kp_term + ff_ext;
                r_sign_d <= r_deriv_gain[DATA_W-1] ^ diff_w[ERR_W];
            end
            ST_WAITI: begin
                r_tmp <= int_ext + inc_term;
            end
            ST_IACC: begin
                r_drv <= r_drv + int_ext;
            end
            ST_WAITD: begin
                if (r_dt != '0 && div_done) begin
                    r_drv <= r_drv + der_term;
                end
            end
            ST_CLAMP: begin
                r_drv <= n_drv_clamped;
            end
            ST_OUT: begin
                if (out_load) begin
                    r_out_drive <= n_whole;
                end
            end
            default: begin
            end
        endcase
    end

    pidt_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    pidt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // a clear transaction leaves integral and last error at zero
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && i_cmd.op == OP_CLEAR) |=> (r_int == '0 && r_prev == '0))
        else $error("clear did not zero controller state");

    // a step transaction blocks the command side while it runs
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && i_cmd.op == OP_STEP) |=> !i_cmd.ready)
        else $error("command side ready during a step");

    // a result appears only when the sequencer hands one over
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state) == ST_OUT)
        else $error("result valid without a finished step");
endmodule
